// File: sv/cau_pkg.sv
package cau_pkg;

   // operation codes
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   // fraction bits of Q16.16 and quotient bits kept by the divider
   localparam int FRAC_W = 16;
   localparam int QUOT_W = 33;
   localparam int LOW_W  = QUOT_W;
   localparam int DIV_STEPS = QUOT_W;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] a_re;
      logic signed [31:0] a_im;
      logic signed [31:0] b_re;
      logic signed [31:0] b_im;
   } cau_req_type;

   typedef struct packed {
      logic signed [31:0] res_re;
      logic signed [31:0] res_im;
      logic               overflow;
      logic               div_zero;
   } cau_rsp_type;

   // classified item from front to back
   typedef struct packed {
      logic [1:0]         op;
      logic               dz;
      logic signed [31:0] a_re;
      logic signed [31:0] a_im;
      logic signed [31:0] b_re;
      logic signed [31:0] b_im;
   } cau_cmd_type;

   // one part (real or imaginary) on its way through the divider
   typedef struct packed {
      logic                neg;
      logic [63:0]         mag;
      logic                big;
      logic [63:0]         rem;
      logic [QUOT_W-1:0]   quot;
      logic [LOW_W-1:0]    low;
   } cau_lane_type;

   typedef struct packed {
      logic [1:0]   op;
      logic         dz;
      logic [63:0]  den;
      cau_lane_type re;
      cau_lane_type im;
   } cau_dstage_type;

endpackage

// File: sv/complex_arith_unit.sv
// path of an accepted item: queue, products, numerators, magnitude, divider setup,
// 33 quotient stages, output
// throughput: one item per cycle when not stalled; one quotient bit per divider stage
// a 4-entry queue separates the input side from the stalling pipeline
// reset: synchronous, active high; clears queue and all valid bits, no result pending
module complex_arith_unit import cau_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  cau_req_type req_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output cau_rsp_type rsp_item
);

   logic        cmd_valid;
   logic        cmd_ready;
   cau_cmd_type cmd_item;

   // accept and classify
   cau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_item  (cmd_item)
   );

   // arithmetic pipeline
   cau_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_item  (cmd_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

// File: sv/cau_front.sv
module cau_front import cau_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  cau_req_type req_item,
   output logic        cmd_valid,
   input  logic        cmd_ready,
   output cau_cmd_type cmd_item
);

   cau_cmd_type       queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push, pop;
   cau_cmd_type       cmd_new;

   // classify: flag a divide by a zero divisor up front
   always_comb begin
      cmd_new.op   = req_item.req_type;
      cmd_new.dz   = (req_item.req_type == OP_DIV) && (req_item.b_re == 32'sd0) &&
                     (req_item.b_im == 32'sd0);
      cmd_new.a_re = req_item.a_re;
      cmd_new.a_im = req_item.a_im;
      cmd_new.b_re = req_item.b_re;
      cmd_new.b_im = req_item.b_im;
   end

   assign req_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd_item  = queue_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   // queue pointers
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// File: sv/cau_div_step.sv
module cau_div_step import cau_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic           valid_i,
   input  cau_dstage_type stage_i,
   output logic           valid_o,
   output cau_dstage_type stage_o
);

   logic           valid_ff;
   cau_dstage_type stage_ff, stage_in;

   // one restoring step on a single part
   function automatic cau_lane_type step(input cau_lane_type l, input logic [63:0] den);
      logic [64:0]  r2;
      logic [64:0]  diff;
      logic         ge;
      cau_lane_type o;
      r2   = {l.rem, l.low[LOW_W-1]};
      diff = r2 - {1'b0, den};
      ge   = (r2 >= {1'b0, den});
      o      = l;
      o.rem  = ge ? diff[63:0] : r2[63:0];
      o.quot = {l.quot[QUOT_W-2:0], ge};
      o.low  = {l.low[LOW_W-2:0], 1'b0};
      return o;
   endfunction

   always_comb begin
      stage_in    = stage_i;
      stage_in.re = step(stage_i.re, stage_i.den);
      stage_in.im = step(stage_i.im, stage_i.den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign valid_o = valid_ff;
   assign stage_o = stage_ff;

endmodule

// File: sv/cau_back.sv
module cau_back import cau_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cau_cmd_type cmd_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output cau_rsp_type rsp_item
);

   logic advance;

   // stage 1: products and short sums
   logic               s1_valid_ff;
   logic [1:0]         s1_op_ff;
   logic               s1_dz_ff;
   logic signed [63:0] s1_rr_ff, s1_ii_ff, s1_ri_ff, s1_ir_ff, s1_bbr_ff, s1_bbi_ff;
   logic signed [32:0] s1_sr_ff, s1_si_ff;

   // stage 2: exact numerators and denominator
   logic               s2_valid_ff;
   logic [1:0]         s2_op_ff;
   logic               s2_dz_ff;
   logic signed [64:0] s2_nre_ff, s2_nre_in, s2_nim_ff, s2_nim_in;
   logic [63:0]        s2_den_ff;

   // stage 3: sign and magnitude
   logic               s3_valid_ff;
   logic [1:0]         s3_op_ff;
   logic               s3_dz_ff;
   logic [63:0]        s3_den_ff;
   logic               s3_nre_ff, s3_nim_ff;
   logic [63:0]        s3_mre_ff, s3_mim_ff;
   logic [64:0]        s3_negre, s3_negim;

   // divider chain
   logic           dvalid [DIV_STEPS+1];
   cau_dstage_type dstage [DIV_STEPS+1];
   cau_dstage_type d0_in;
   logic           d0_valid_ff;
   cau_dstage_type d0_stage_ff;

   logic        rsp_valid_ff;
   cau_rsp_type rsp_item_ff, rsp_item_in;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         d0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= cmd_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         d0_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= dvalid[DIV_STEPS];
      end
   end

   // stage 1 multiplies
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff  <= cmd_item.op;
         s1_dz_ff  <= cmd_item.dz;
         s1_rr_ff  <= 64'(cmd_item.a_re) * 64'(cmd_item.b_re);
         s1_ii_ff  <= 64'(cmd_item.a_im) * 64'(cmd_item.b_im);
         s1_ri_ff  <= 64'(cmd_item.a_re) * 64'(cmd_item.b_im);
         s1_ir_ff  <= 64'(cmd_item.a_im) * 64'(cmd_item.b_re);
         s1_bbr_ff <= 64'(cmd_item.b_re) * 64'(cmd_item.b_re);
         s1_bbi_ff <= 64'(cmd_item.b_im) * 64'(cmd_item.b_im);
         if (cmd_item.op == OP_SUB) begin
            s1_sr_ff <= 33'(cmd_item.a_re) - 33'(cmd_item.b_re);
            s1_si_ff <= 33'(cmd_item.a_im) - 33'(cmd_item.b_im);
         end else begin
            s1_sr_ff <= 33'(cmd_item.a_re) + 33'(cmd_item.b_re);
            s1_si_ff <= 33'(cmd_item.a_im) + 33'(cmd_item.b_im);
         end
      end
   end

   // stage 2 numerator select
   always_comb begin
      unique case (s1_op_ff) inside
         OP_ADD, OP_SUB: begin
            s2_nre_in = 65'(s1_sr_ff);
            s2_nim_in = 65'(s1_si_ff);
         end
         OP_MUL: begin
            s2_nre_in = 65'(s1_rr_ff) - 65'(s1_ii_ff);
            s2_nim_in = 65'(s1_ri_ff) + 65'(s1_ir_ff);
         end
         default: begin
            s2_nre_in = 65'(s1_rr_ff) + 65'(s1_ii_ff);
            s2_nim_in = 65'(s1_ir_ff) - 65'(s1_ri_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_op_ff  <= s1_op_ff;
         s2_dz_ff  <= s1_dz_ff;
         s2_nre_ff <= s2_nre_in;
         s2_nim_ff <= s2_nim_in;
         s2_den_ff <= s1_bbr_ff[63:0] + s1_bbi_ff[63:0];
      end
   end

   // stage 3 magnitude
   assign s3_negre = -s2_nre_ff;
   assign s3_negim = -s2_nim_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_op_ff  <= s2_op_ff;
         s3_dz_ff  <= s2_dz_ff;
         s3_den_ff <= s2_den_ff;
         s3_nre_ff <= s2_nre_ff[64];
         s3_nim_ff <= s2_nim_ff[64];
         s3_mre_ff <= s2_nre_ff[64] ? s3_negre[63:0] : s2_nre_ff[63:0];
         s3_mim_ff <= s2_nim_ff[64] ? s3_negim[63:0] : s2_nim_ff[63:0];
      end
   end

   // divider setup: range check and first partial remainder
   function automatic cau_lane_type lane_init(input logic neg, input logic [63:0] mag,
                                              input logic [63:0] den);
      cau_lane_type l;
      l.neg  = neg;
      l.mag  = mag;
      l.big  = ({{(QUOT_W-FRAC_W){1'b0}}, mag} >= {den, {(QUOT_W-FRAC_W){1'b0}}});
      l.rem  = {{(QUOT_W-FRAC_W){1'b0}}, mag[63:QUOT_W-FRAC_W]};
      l.quot = '0;
      l.low  = {mag[QUOT_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
      return l;
   endfunction

   always_comb begin
      d0_in.op  = s3_op_ff;
      d0_in.dz  = s3_dz_ff;
      d0_in.den = s3_den_ff;
      d0_in.re  = lane_init(s3_nre_ff, s3_mre_ff, s3_den_ff);
      d0_in.im  = lane_init(s3_nim_ff, s3_mim_ff, s3_den_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d0_stage_ff <= d0_in;
      end
   end

   assign dvalid[0] = d0_valid_ff;
   assign dstage[0] = d0_stage_ff;

   // one quotient bit per stage
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      cau_div_step u_step (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .valid_i (dvalid[k]),
         .stage_i (dstage[k]),
         .valid_o (dvalid[k+1]),
         .stage_o (dstage[k+1])
      );
   end

   // pick magnitude by operation and saturate
   function automatic logic [32:0] finish(input logic [1:0] op, input cau_lane_type l);
      logic [63:0] m;
      logic [31:0] v;
      logic        ovf;
      case (op)
         OP_MUL:  m = l.mag >> FRAC_W;
         OP_DIV:  m = l.big ? '1 : 64'(l.quot);
         default: m = l.mag;
      endcase
      ovf = 1'b0;
      if (l.neg) begin
         if (m > 64'h8000_0000) begin
            ovf = 1'b1;
            m   = 64'h8000_0000;
         end
         v = -m[31:0];
      end else begin
         if (m > 64'h7FFF_FFFF) begin
            ovf = 1'b1;
            m   = 64'h7FFF_FFFF;
         end
         v = m[31:0];
      end
      return {ovf, v};
   endfunction

   always_comb begin
      logic [32:0] fr, fi;
      fr = finish(dstage[DIV_STEPS].op, dstage[DIV_STEPS].re);
      fi = finish(dstage[DIV_STEPS].op, dstage[DIV_STEPS].im);
      if (dstage[DIV_STEPS].dz) begin
         rsp_item_in.res_re   = '0;
         rsp_item_in.res_im   = '0;
         rsp_item_in.overflow = 1'b0;
         rsp_item_in.div_zero = 1'b1;
      end else begin
         rsp_item_in.res_re   = fr[31:0];
         rsp_item_in.res_im   = fi[31:0];
         rsp_item_in.overflow = fr[32] | fi[32];
         rsp_item_in.div_zero = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// File: sv/cau_checker.sv
module cau_sva_checker import cau_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input cau_rsp_type rsp_item
);

   // a stalled item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("result item changed while stalled");

   // nothing comes out right after reset
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // zero divisor gives a clean zero
   a_dz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.div_zero |->
         rsp_item.res_re == 32'sd0 && rsp_item.res_im == 32'sd0 && !rsp_item.overflow)
      else $error("divide by zero result not zero");

   // overflow only with a saturated part
   a_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.overflow |->
         rsp_item.res_re == 32'h7FFF_FFFF || rsp_item.res_re == 32'h8000_0000 ||
         rsp_item.res_im == 32'h7FFF_FFFF || rsp_item.res_im == 32'h8000_0000)
      else $error("overflow flag without saturated part");

endmodule

bind complex_arith_unit cau_sva_checker u_cau_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);
